// File: src/tto_pkg.sv
// ----------------------------------------------------------------------------
// tto_pkg
// Shared constants for the triangle overlap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tto_pkg;

  // two triangles, three vertices each
  localparam int unsigned NumTri = 2;
  localparam int unsigned NumPt  = 3;
  // edges of the first triangle at B0, and of the second at B1
  localparam int unsigned NumEdge = 2;

endpackage

`default_nettype wire

// File: src/tto_cross.sv
// ----------------------------------------------------------------------------
// tto_cross
// Two-stage 2D cross product a.x*b.y - a.y*b.x: products, then difference.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_cross #(
  parameter int unsigned DW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] ax_i,
  input  logic signed [DW-1:0] ay_i,
  input  logic signed [DW-1:0] bx_i,
  input  logic signed [DW-1:0] by_i,
  output logic signed [2*DW:0] cross_o
);

  logic signed [2*DW-1:0] p1_d, p1_q, p2_d, p2_q;
  logic signed [2*DW:0]   r_d, r_q;

  // product stage
  assign p1_d = ax_i * by_i;
  assign p2_d = ay_i * bx_i;

  // difference stage, one guard bit
  assign r_d = {p1_q[2*DW-1], p1_q} - {p2_q[2*DW-1], p2_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      r_q  <= r_d;
    end
  end

  assign cross_o = r_q;

endmodule

`default_nettype wire

// File: src/tto_eval.sv
// ----------------------------------------------------------------------------
// tto_eval
// Sign and range tests on the cross products: vertex-inside and edge-crossing
// flags, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_eval
  import tto_pkg::*;
#(
  parameter int unsigned DW = 17
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [2*DW:0] den_i [NumTri],
  input  logic signed [2*DW:0] sn_i  [NumTri][NumPt],
  input  logic signed [2*DW:0] tn_i  [NumTri][NumPt],
  input  logic signed [2*DW:0] c1_i  [NumEdge],
  input  logic signed [2*DW:0] c2_i  [NumEdge][NumEdge],
  input  logic signed [2*DW:0] c3_i  [NumEdge],
  input  logic signed [2*DW:0] c4_i  [NumEdge][NumEdge],
  input  logic signed [DW-1:0] dx_i  [NumEdge],
  input  logic signed [DW-1:0] dy_i  [NumEdge],
  input  logic signed [DW-1:0] ex_i,
  input  logic signed [DW-1:0] ey_i,
  input  logic signed [DW-1:0] fx_i  [NumEdge],
  input  logic signed [DW-1:0] fy_i  [NumEdge],
  output logic                 hit_o
);

  localparam int unsigned CW = 2 * DW + 1;
  localparam int unsigned NW = DW + 1;

  logic [NumTri*NumPt-1:0]     in_d, in_q;
  logic [NumEdge*NumEdge-1:0]  sg_d, sg_q;

  // vertex strictly inside the other triangle
  always_comb begin
    logic signed [CW:0] sum;
    logic signed [CW:0] den;
    for (int i = 0; i < NumTri; i++) begin
      for (int j = 0; j < NumPt; j++) begin
        sum = {sn_i[i][j][CW-1], sn_i[i][j]} + {tn_i[i][j][CW-1], tn_i[i][j]};
        den = {den_i[i][CW-1], den_i[i]};
        if (den_i[i] > 0) begin
          in_d[i*NumPt+j] = (sn_i[i][j] > 0) && (tn_i[i][j] > 0) && (sum < den);
        end else if (den_i[i] < 0) begin
          in_d[i*NumPt+j] = (sn_i[i][j] < 0) && (tn_i[i][j] < 0) && (sum > den);
        end else begin
          in_d[i*NumPt+j] = 1'b0;
        end
      end
    end
  end

  // edge pair crossing, collinear case by projection on one axis
  always_comb begin
    logic signed [NW-1:0] n1, n2, dd;
    for (int a = 0; a < NumEdge; a++) begin
      for (int b = 0; b < NumEdge; b++) begin
        if (dx_i[a] == 0) begin
          n1 = NW'(ey_i);
          n2 = NW'(fy_i[b]);
          dd = NW'(dy_i[a]);
        end else begin
          n1 = NW'(ex_i);
          n2 = NW'(fx_i[b]);
          dd = NW'(dx_i[a]);
        end
        if (dd < 0) begin
          n1 = -n1;
          n2 = -n2;
          dd = -dd;
        end
        if (c1_i[a] == 0 && c2_i[a][b] == 0) begin
          if (dx_i[a] == 0 && dy_i[a] == 0) begin
            sg_d[a*NumEdge+b] = 1'b0;
          end else begin
            sg_d[a*NumEdge+b] = (n1 > 0 && n1 < dd) || (n2 > 0 && n2 < dd) ||
                                (n1 < 0 && n2 > dd) || (n2 < 0 && n1 > dd);
          end
        end else if ((c1_i[a] > 0 && c2_i[a][b] > 0) ||
                     (c1_i[a] < 0 && c2_i[a][b] < 0)) begin
          sg_d[a*NumEdge+b] = 1'b0;
        end else begin
          sg_d[a*NumEdge+b] = (c3_i[b] > 0 && c4_i[a][b] < 0) ||
                              (c3_i[b] < 0 && c4_i[a][b] > 0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q <= in_d;
      sg_q <= sg_d;
    end
  end

  assign hit_o = (|in_q) | (|sg_q);

endmodule

`default_nettype wire

// File: src/triangle_triangle_overlap.sv
// ----------------------------------------------------------------------------
// triangle_triangle_overlap
// Overlap test of two 2D triangles in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item: the six vertices
//   A0 B0 C0 A1 B1 C1, each COORD_BITS wide, signed. Output channel
//   out_valid_o/out_ready_i returns one flag overlap_o per item, in order.
// Pipeline: five register stages (differences, products, cross products, sign
//   tests, result register); the first stage loads at the accepting edge, and
//   out_valid_o rises when the item reaches the result register.
// Throughput: one item per cycle unless stalled; every stage holds one item,
//   and the 52 cross-product multipliers each do one product per cycle.
// Stall: when the result register holds an untaken item and out_ready_i is
//   low, the whole pipeline freezes and in_ready_o drops; nothing is lost.
//   in_ready_o stays high while the result is being taken.
// Reset: rst_ni clears all valid bits; the block is empty and ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_triangle_overlap
  import tto_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a0_x_i,
  input  logic signed [COORD_BITS-1:0] a0_y_i,
  input  logic signed [COORD_BITS-1:0] b0_x_i,
  input  logic signed [COORD_BITS-1:0] b0_y_i,
  input  logic signed [COORD_BITS-1:0] c0_x_i,
  input  logic signed [COORD_BITS-1:0] c0_y_i,
  input  logic signed [COORD_BITS-1:0] a1_x_i,
  input  logic signed [COORD_BITS-1:0] a1_y_i,
  input  logic signed [COORD_BITS-1:0] b1_x_i,
  input  logic signed [COORD_BITS-1:0] b1_y_i,
  input  logic signed [COORD_BITS-1:0] c1_x_i,
  input  logic signed [COORD_BITS-1:0] c1_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         overlap_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned CW = 2 * DW + 1;

  logic       en;
  logic [4:0] vld_q;

  logic signed [DW-1:0] vx [NumTri][NumPt];
  logic signed [DW-1:0] vy [NumTri][NumPt];

  // stage 1: edges and points relative to each base vertex B
  logic signed [DW-1:0] e0x_q [NumTri], e0y_q [NumTri];
  logic signed [DW-1:0] e1x_q [NumTri], e1y_q [NumTri];
  logic signed [DW-1:0] px_q  [NumTri][NumPt], py_q [NumTri][NumPt];

  // copies of the first triangle's vectors, aligned to the cross results
  logic signed [DW-1:0] s2ex_q [NumEdge], s2ey_q [NumEdge];
  logic signed [DW-1:0] s3ex_q [NumEdge], s3ey_q [NumEdge];
  logic signed [DW-1:0] s2px_q [NumPt],   s2py_q [NumPt];
  logic signed [DW-1:0] s3px_q [NumPt],   s3py_q [NumPt];

  logic signed [CW-1:0] den [NumTri];
  logic signed [CW-1:0] sn  [NumTri][NumPt];
  logic signed [CW-1:0] tn  [NumTri][NumPt];
  logic signed [CW-1:0] c1  [NumEdge];
  logic signed [CW-1:0] c2  [NumEdge][NumEdge];
  logic signed [CW-1:0] c3  [NumEdge];
  logic signed [CW-1:0] c4  [NumEdge][NumEdge];

  logic signed [DW-1:0] dx [NumEdge], dy [NumEdge];
  logic signed [DW-1:0] fx [NumEdge], fy [NumEdge];

  logic hit;
  logic overlap_q;

  // whole pipe advances unless the result register is stalled
  assign en          = ~vld_q[4] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[4];
  assign overlap_o   = overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // sign-extended vertex table
  assign vx[0][0] = DW'(a0_x_i);
  assign vy[0][0] = DW'(a0_y_i);
  assign vx[0][1] = DW'(b0_x_i);
  assign vy[0][1] = DW'(b0_y_i);
  assign vx[0][2] = DW'(c0_x_i);
  assign vy[0][2] = DW'(c0_y_i);
  assign vx[1][0] = DW'(a1_x_i);
  assign vy[1][0] = DW'(a1_y_i);
  assign vx[1][1] = DW'(b1_x_i);
  assign vy[1][1] = DW'(b1_y_i);
  assign vx[1][2] = DW'(c1_x_i);
  assign vy[1][2] = DW'(c1_y_i);

  // stage 1 and the delay copies
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumTri; i++) begin
        e0x_q[i] <= vx[i][0] - vx[i][1];
        e0y_q[i] <= vy[i][0] - vy[i][1];
        e1x_q[i] <= vx[i][2] - vx[i][1];
        e1y_q[i] <= vy[i][2] - vy[i][1];
        for (int j = 0; j < NumPt; j++) begin
          px_q[i][j] <= vx[1-i][j] - vx[i][1];
          py_q[i][j] <= vy[1-i][j] - vy[i][1];
        end
      end
      s2ex_q[0] <= e0x_q[0];
      s2ey_q[0] <= e0y_q[0];
      s2ex_q[1] <= e1x_q[0];
      s2ey_q[1] <= e1y_q[0];
      s3ex_q    <= s2ex_q;
      s3ey_q    <= s2ey_q;
      s2px_q    <= px_q[0];
      s2py_q    <= py_q[0];
      s3px_q    <= s2px_q;
      s3py_q    <= s2py_q;
    end
  end

  // stages 2 and 3: cross products
  for (genvar i = 0; i < NumTri; i++) begin : g_tri
    tto_cross #(.DW(DW)) u_den (
      .clk_i, .en_i(en),
      .ax_i(e1x_q[i]), .ay_i(e1y_q[i]), .bx_i(e0x_q[i]), .by_i(e0y_q[i]),
      .cross_o(den[i])
    );
    for (genvar j = 0; j < NumPt; j++) begin : g_pt
      tto_cross #(.DW(DW)) u_sn (
        .clk_i, .en_i(en),
        .ax_i(e1x_q[i]), .ay_i(e1y_q[i]), .bx_i(px_q[i][j]), .by_i(py_q[i][j]),
        .cross_o(sn[i][j])
      );
      tto_cross #(.DW(DW)) u_tn (
        .clk_i, .en_i(en),
        .ax_i(px_q[i][j]), .ay_i(py_q[i][j]), .bx_i(e0x_q[i]), .by_i(e0y_q[i]),
        .cross_o(tn[i][j])
      );
    end
  end

  // edge a of the first triangle (B0-A0, B0-C0), edge b of the second
  for (genvar a = 0; a < NumEdge; a++) begin : g_ea
    localparam int unsigned QI = (a == 0) ? 0 : 2;
    tto_cross #(.DW(DW)) u_c1 (
      .clk_i, .en_i(en),
      .ax_i((a == 0) ? e0x_q[0] : e1x_q[0]), .ay_i((a == 0) ? e0y_q[0] : e1y_q[0]),
      .bx_i(px_q[0][1]), .by_i(py_q[0][1]),
      .cross_o(c1[a])
    );
    tto_cross #(.DW(DW)) u_c3 (
      .clk_i, .en_i(en),
      .ax_i(px_q[0][1]), .ay_i(py_q[0][1]),
      .bx_i((a == 0) ? e0x_q[1] : e1x_q[1]), .by_i((a == 0) ? e0y_q[1] : e1y_q[1]),
      .cross_o(c3[a])
    );
    assign dx[a] = s3ex_q[a];
    assign dy[a] = s3ey_q[a];
    assign fx[a] = s3px_q[QI];
    assign fy[a] = s3py_q[QI];
    for (genvar b = 0; b < NumEdge; b++) begin : g_eb
      localparam int unsigned SI = (b == 0) ? 0 : 2;
      tto_cross #(.DW(DW)) u_c2 (
        .clk_i, .en_i(en),
        .ax_i((a == 0) ? e0x_q[0] : e1x_q[0]), .ay_i((a == 0) ? e0y_q[0] : e1y_q[0]),
        .bx_i(px_q[0][SI]), .by_i(py_q[0][SI]),
        .cross_o(c2[a][b])
      );
      tto_cross #(.DW(DW)) u_c4 (
        .clk_i, .en_i(en),
        .ax_i((b == 0) ? e0x_q[1] : e1x_q[1]), .ay_i((b == 0) ? e0y_q[1] : e1y_q[1]),
        .bx_i(px_q[1][QI]), .by_i(py_q[1][QI]),
        .cross_o(c4[a][b])
      );
    end
  end

  // stage 4: sign tests
  tto_eval #(.DW(DW)) u_eval (
    .clk_i,
    .en_i (en),
    .den_i(den),
    .sn_i (sn),
    .tn_i (tn),
    .c1_i (c1),
    .c2_i (c2),
    .c3_i (c3),
    .c4_i (c4),
    .dx_i (dx),
    .dy_i (dy),
    .ex_i (s3px_q[1]),
    .ey_i (s3py_q[1]),
    .fx_i (fx),
    .fy_i (fy),
    .hit_o(hit)
  );

  // stage 5: result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      overlap_q <= hit;
    end
  end

endmodule

`default_nettype wire
